/* rtl/core/bitmap_box_downscale_threshold_unit_macros.svh */
// Assertion macros shared by the bitmap box downscale RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BITMAP_BOX_DOWNSCALE_THRESHOLD_UNIT_MACROS_SVH
`define BITMAP_BOX_DOWNSCALE_THRESHOLD_UNIT_MACROS_SVH

// Same-cycle implication, switched off during reset
`define BBDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off during reset
`define BBDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bbdt_pkg.sv */
// Shared types, constants and helper functions for the bitmap box downscaler.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package bbdt_pkg;

   // Default build parameters
   localparam int SCALE_RATIO_DEF   = 2;
   localparam int MAX_OUT_WIDTH_DEF = 32;

   // Source geometry
   localparam int BYTE_BITS  = 8;
   localparam int BIT_IDX_W  = $clog2(BYTE_BITS);
   localparam int DIM_W      = 7;
   localparam int DIM_MIN    = 2;
   localparam int DIM_MAX    = 64;
   localparam int BYTE_POS   = DIM_MAX / BYTE_BITS;
   localparam int BYTE_IDX_W = $clog2(BYTE_POS);
   localparam int ROW_W      = 6;

   // Result fields
   localparam int COORD_W  = 5;
   localparam int COLOUR_W = 4;

   // Tile counters and colour thresholds
   localparam int CNT_W      = 3;
   localparam int CNT_MAX    = 7;
   localparam int FORE_LEVEL = 2;
   localparam int HALF_LEVEL = 1;
   localparam logic [COLOUR_W-1:0] HALF_MASK = 4'd14;

   // Width of the per-slot column limits ((tile + 2) * ratio)
   localparam int LIM_W = 10;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [DIM_W-1:0]    WIDTH_RST  = 7'd32;
   localparam logic [DIM_W-1:0]    HEIGHT_RST = 7'd32;
   localparam logic [COLOUR_W-1:0] FORE_RST   = 4'd3;
   localparam logic [COLOUR_W-1:0] BACK_RST   = 4'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_FORE_COLOUR   = 2'd2,
      CSR_BACK_COLOUR   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    source_width;
      logic [DIM_W-1:0]    source_height;
      logic [COLOUR_W-1:0] fore_colour;
      logic [COLOUR_W-1:0] back_colour;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]  out_x;
      logic [COORD_W-1:0]  out_y;
      logic [COLOUR_W-1:0] colour;
      logic                run_last;
      logic                image_done;
   } rsp_item_type;

   // Saturate a programmed dimension to the supported range
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(DIM_MIN)) r = DIM_W'(DIM_MIN);
      else if (v > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
      else r = v;
      return r;
   endfunction

   // Threshold the ink count of one tile into a palette index
   function automatic logic [COLOUR_W-1:0] pick_colour(input logic [CNT_W-1:0] cnt,
                                                      input logic [COLOUR_W-1:0] fore,
                                                      input logic [COLOUR_W-1:0] back);
      logic [COLOUR_W-1:0] r;
      if (cnt > CNT_W'(FORE_LEVEL)) r = fore;
      else if (cnt > CNT_W'(HALF_LEVEL)) r = fore & HALF_MASK;
      else r = back;
      return r;
   endfunction

endpackage

/* rtl/core/bbdt_tile_acc.sv */
// Tile ink counters, scan position and per-beat result slot builder.
// Depends on bbdt_pkg.
`timescale 1ns / 1ps

module bbdt_tile_acc #(
   parameter int SCALE_RATIO   = bbdt_pkg::SCALE_RATIO_DEF,
   parameter int MAX_OUT_WIDTH = bbdt_pkg::MAX_OUT_WIDTH_DEF,
   parameter int SLOTS         = (bbdt_pkg::BYTE_BITS + SCALE_RATIO - 1) / SCALE_RATIO,
   parameter int N_W           = $clog2(SLOTS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [bbdt_pkg::BYTE_BITS-1:0]     bits_data,
   input  bbdt_pkg::cfg_type                  cfg,
   output bbdt_pkg::rsp_item_type             batch_item [SLOTS],
   output logic [N_W-1:0]                     batch_cnt
);

   localparam int SUB_W = $clog2(SCALE_RATIO);

   // Scan position: byte within row, source row, row within tile, tile row
   logic [bbdt_pkg::BYTE_IDX_W-1:0] kb_ff,   kb_in;
   logic [bbdt_pkg::ROW_W-1:0]      row_ff,  row_in;
   logic [SUB_W-1:0]                sub_ff,  sub_in;
   logic [bbdt_pkg::COORD_W-1:0]    trow_ff, trow_in;

   logic [bbdt_pkg::CNT_W-1:0] cnt_ff  [MAX_OUT_WIDTH];
   logic [bbdt_pkg::CNT_W-1:0] cnt_new [MAX_OUT_WIDTH];

   logic [bbdt_pkg::DIM_W-1:0]   width;
   logic [bbdt_pkg::DIM_W-1:0]   height;
   logic                         row_wrap;
   logic [bbdt_pkg::ROW_W-1:0]   eff_row;
   logic [SUB_W-1:0]             eff_sub;
   logic [bbdt_pkg::COORD_W-1:0] eff_trow;
   logic                         tile_row_start;
   logic                         tile_last_row;
   logic                         image_last_row;
   logic [bbdt_pkg::BYTE_IDX_W:0] byte_next;
   logic [bbdt_pkg::DIM_W-1:0]   col_next;
   logic                         row_end;
   logic [bbdt_pkg::DIM_W-1:0]   row_next;

   // Effective geometry; a row beyond a lowered height restarts the image
   assign width          = bbdt_pkg::clamp_dim(cfg.source_width);
   assign height         = bbdt_pkg::clamp_dim(cfg.source_height);
   assign row_wrap       = {1'b0, row_ff} >= height;
   assign eff_row        = row_wrap ? '0 : row_ff;
   assign eff_sub        = row_wrap ? '0 : sub_ff;
   assign eff_trow       = row_wrap ? '0 : trow_ff;
   assign tile_row_start = (kb_ff == '0) && (eff_sub == '0);
   assign tile_last_row  = eff_sub == SUB_W'(SCALE_RATIO - 1);
   assign image_last_row = ({1'b0, eff_row} + bbdt_pkg::DIM_W'(SCALE_RATIO)) >= height;
   assign byte_next      = {1'b0, kb_ff} + 1'b1;
   assign col_next       = bbdt_pkg::DIM_W'({byte_next, {bbdt_pkg::BIT_IDX_W{1'b0}}});
   assign row_end        = col_next >= width;
   assign row_next       = {1'b0, eff_row} + 1'b1;

   // Next scan position
   always_comb begin
      kb_in   = byte_next[bbdt_pkg::BYTE_IDX_W-1:0];
      row_in  = eff_row;
      sub_in  = eff_sub;
      trow_in = eff_trow;
      if (row_end) begin
         kb_in = '0;
         if (row_next >= height) begin
            row_in  = '0;
            sub_in  = '0;
            trow_in = '0;
         end else begin
            row_in = row_next[bbdt_pkg::ROW_W-1:0];
            if (tile_last_row) begin
               sub_in  = '0;
               trow_in = eff_trow + 1'b1;
            end else begin
               sub_in = eff_sub + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_ff   <= '0;
         row_ff  <= '0;
         sub_ff  <= '0;
         trow_ff <= '0;
      end else if (step) begin
         kb_ff   <= kb_in;
         row_ff  <= row_in;
         sub_ff  <= sub_in;
         trow_ff <= trow_in;
      end
   end

   // Per-tile ink count: each tile looks only at its own source columns
   for (genvar t = 0; t < MAX_OUT_WIDTH; t++) begin : g_tile
      logic [SCALE_RATIO-1:0] ink;

      for (genvar i = 0; i < SCALE_RATIO; i++) begin : g_pix
         localparam int COL = t * SCALE_RATIO + i;
         if (COL < bbdt_pkg::DIM_MAX) begin : g_in
            assign ink[i] = (kb_ff == bbdt_pkg::BYTE_IDX_W'(COL / bbdt_pkg::BYTE_BITS))
                            && !bits_data[COL % bbdt_pkg::BYTE_BITS]
                            && (width > bbdt_pkg::DIM_W'(COL));
         end else begin : g_out
            assign ink[i] = 1'b0;
         end
      end

      // Saturating add; the store starts from zero on the first beat of a tile row
      always_comb begin
         logic [bbdt_pkg::CNT_W:0] sum;
         sum = tile_row_start ? '0 : {1'b0, cnt_ff[t]};
         for (int i = 0; i < SCALE_RATIO; i++) begin
            sum = sum + {{bbdt_pkg::CNT_W{1'b0}}, ink[i]};
         end
         cnt_new[t] = (sum > (bbdt_pkg::CNT_W + 1)'(bbdt_pkg::CNT_MAX))
                      ? bbdt_pkg::CNT_W'(bbdt_pkg::CNT_MAX) : sum[bbdt_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < MAX_OUT_WIDTH; t++) cnt_ff[t] <= '0;
      end else if (step) begin
         for (int t = 0; t < MAX_OUT_WIDTH; t++) cnt_ff[t] <= cnt_new[t];
      end
   end

   localparam int LIM_W_L = bbdt_pkg::LIM_W;

   // Tiles whose last column falls in byte k, fixed at elaboration
   logic [bbdt_pkg::CNT_W-1:0]   kj_cnt     [bbdt_pkg::BYTE_POS][SLOTS];
   logic                         kj_ok      [bbdt_pkg::BYTE_POS][SLOTS];
   logic [LIM_W_L-1:0]           kj_lim_in  [bbdt_pkg::BYTE_POS][SLOTS];
   logic [LIM_W_L-1:0]           kj_lim_out [bbdt_pkg::BYTE_POS][SLOTS];
   logic [bbdt_pkg::COORD_W-1:0] kj_x       [bbdt_pkg::BYTE_POS][SLOTS];
   logic                         kj_edge    [bbdt_pkg::BYTE_POS][SLOTS];

   for (genvar k = 0; k < bbdt_pkg::BYTE_POS; k++) begin : g_pos
      for (genvar j = 0; j < SLOTS; j++) begin : g_slot
         localparam int T  = (k * bbdt_pkg::BYTE_BITS) / SCALE_RATIO + j;
         localparam bit OK = (T * SCALE_RATIO + SCALE_RATIO - 1
                              <= k * bbdt_pkg::BYTE_BITS + bbdt_pkg::BYTE_BITS - 1)
                             && (T < MAX_OUT_WIDTH);
         localparam int TI = OK ? T : 0;
         assign kj_cnt[k][j]     = cnt_new[TI];
         assign kj_ok[k][j]      = OK;
         assign kj_lim_in[k][j]  = LIM_W_L'((T + 1) * SCALE_RATIO);
         assign kj_lim_out[k][j] = LIM_W_L'((T + 2) * SCALE_RATIO);
         assign kj_x[k][j]       = bbdt_pkg::COORD_W'(T);
         assign kj_edge[k][j]    = (T + 1 >= MAX_OUT_WIDTH);
      end
   end

   // Result slots for the current beat, in column order
   logic [SLOTS-1:0]   emit;
   logic [SLOTS-1:0]   emit_nxt;
   logic [LIM_W_L-1:0] width_ext;

   assign width_ext = {{(LIM_W_L - bbdt_pkg::DIM_W){1'b0}}, width};
   assign emit_nxt  = emit >> 1;

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         emit[j] = kj_ok[kb_ff][j] && tile_last_row && (width_ext >= kj_lim_in[kb_ff][j]);
      end
   end

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         batch_item[j].out_x      = kj_x[kb_ff][j];
         batch_item[j].out_y      = eff_trow;
         batch_item[j].colour     = bbdt_pkg::pick_colour(kj_cnt[kb_ff][j],
                                                          cfg.fore_colour, cfg.back_colour);
         batch_item[j].run_last   = emit[j] && !emit_nxt[j];
         batch_item[j].image_done = emit[j] && image_last_row
                                    && (kj_edge[kb_ff][j] || (width_ext < kj_lim_out[kb_ff][j]));
      end
   end

   assign batch_cnt = N_W'($countones(emit));

endmodule

/* rtl/core/bbdt_rsp_queue.sv */
// Result queue: holds the pixels of one beat and hands them out one per cycle while rsp_ready is high.
// Depends on bbdt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bitmap_box_downscale_threshold_unit_macros.svh"

module bbdt_rsp_queue #(
   parameter int SLOTS = 4,
   parameter int N_W   = $clog2(SLOTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bbdt_pkg::rsp_item_type load_item [SLOTS],
   input  logic [N_W-1:0]         load_cnt,
   output logic                   load_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bbdt_pkg::rsp_item_type rsp_item
);

   bbdt_pkg::rsp_item_type item_ff [SLOTS];
   logic [N_W-1:0]         cnt_ff;
   logic                   drain;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_item  = item_ff[0];
   assign drain     = rsp_valid && rsp_ready;
   // Free now, or the last entry leaves this cycle
   assign load_ok   = (cnt_ff == '0) || ((cnt_ff == N_W'(1)) && rsp_ready);

   // Fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= load_cnt;
      end else if (drain) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Entries shift towards the head as pixels leave
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < SLOTS; i++) item_ff[i] <= load_item[i];
      end else if (drain) begin
         for (int i = 0; i < SLOTS - 1; i++) item_ff[i] <= item_ff[i + 1];
      end
   end

   `BBDT_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= N_W'(SLOTS), "queue overfilled")
   `BBDT_ASSERT_NOW(a_load_free, clock, reset, load, (cnt_ff == '0) || ((cnt_ff == N_W'(1)) && rsp_ready), "load over live entries")
   `BBDT_ASSERT_NOW(a_last_at_tail, clock, reset, rsp_valid, item_ff[0].run_last == (cnt_ff == N_W'(1)), "run_last off the final entry")
   `BBDT_ASSERT_NOW(a_done_is_last, clock, reset, rsp_valid && item_ff[0].image_done, item_ff[0].run_last, "image_done before end of run")
   `BBDT_ASSERT_NEXT(a_drain_step, clock, reset, drain && !load, cnt_ff == $past(cnt_ff) - 1'b1, "count lost on drain")

endmodule

/* rtl/core/bitmap_box_downscale_threshold_unit.sv */
// Top level of the bitmap box downscaler: register port, input register, tile
// counters and result queue. Depends on bbdt_pkg, bbdt_tile_acc, bbdt_rsp_queue.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_bitmap_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_out_x, rsp_out_y, rsp_colour,
//                                            rsp_run_last, rsp_image_done
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// An accepted byte waits in the input register; once the queue can take its pixels,
// it updates the tile counters and loads its pixels into the result queue. Bytes that
// finish no tile pass at one per cycle; a byte finishing n tiles (n <= ceil(8/ratio),
// 4 at ratio 2) loads one result pixel per tile, and the queue hands them out in order.
// Such a byte holds req_ready low until the queue is empty or hands out its last pixel.
// Synchronous reset clears the counters, scan position, configuration and valid flags at once.
`timescale 1ns / 1ps

module bitmap_box_downscale_threshold_unit #(
   parameter int SCALE_RATIO   = bbdt_pkg::SCALE_RATIO_DEF,
   parameter int MAX_OUT_WIDTH = bbdt_pkg::MAX_OUT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Source bytes
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bbdt_pkg::BYTE_BITS-1:0]     req_bitmap_byte,
   // Output pixels
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bbdt_pkg::COORD_W-1:0]       rsp_out_x,
   output logic [bbdt_pkg::COORD_W-1:0]       rsp_out_y,
   output logic [bbdt_pkg::COLOUR_W-1:0]      rsp_colour,
   output logic                               rsp_run_last,
   output logic                               rsp_image_done,
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbdt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SLOTS = (bbdt_pkg::BYTE_BITS + SCALE_RATIO - 1) / SCALE_RATIO;
   localparam int N_W   = $clog2(SLOTS + 1);

   bbdt_pkg::cfg_type cfg_ff;

   // Register port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= bbdt_pkg::WIDTH_RST;
         cfg_ff.source_height <= bbdt_pkg::HEIGHT_RST;
         cfg_ff.fore_colour   <= bbdt_pkg::FORE_RST;
         cfg_ff.back_colour   <= bbdt_pkg::BACK_RST;
      end else if (csr_valid) begin
         unique case (bbdt_pkg::csr_index_type'(csr_index))
            bbdt_pkg::CSR_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_wdata;
            bbdt_pkg::CSR_SOURCE_HEIGHT: cfg_ff.source_height <= csr_wdata;
            bbdt_pkg::CSR_FORE_COLOUR:   cfg_ff.fore_colour   <= csr_wdata[bbdt_pkg::COLOUR_W-1:0];
            bbdt_pkg::CSR_BACK_COLOUR:   cfg_ff.back_colour   <= csr_wdata[bbdt_pkg::COLOUR_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                          in_vld_ff;
   logic [bbdt_pkg::BYTE_BITS-1:0] bits_ff;
   logic                          fire;
   logic                          load_ok;
   bbdt_pkg::rsp_item_type        batch_item [SLOTS];
   logic [N_W-1:0]                batch_cnt;
   bbdt_pkg::rsp_item_type        rsp_item;

   // A beat with no pixels never waits on the queue
   assign fire      = in_vld_ff && ((batch_cnt == '0) || load_ok);
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         bits_ff <= req_bitmap_byte;
      end
   end

   bbdt_tile_acc #(
      .SCALE_RATIO   (SCALE_RATIO),
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .SLOTS         (SLOTS),
      .N_W           (N_W)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .bits_data  (bits_ff),
      .cfg        (cfg_ff),
      .batch_item (batch_item),
      .batch_cnt  (batch_cnt)
   );

   bbdt_rsp_queue #(
      .SLOTS (SLOTS),
      .N_W   (N_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && (batch_cnt != '0)),
      .load_item (batch_item),
      .load_cnt  (batch_cnt),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Result fields
   assign rsp_out_x      = rsp_item.out_x;
   assign rsp_out_y      = rsp_item.out_y;
   assign rsp_colour     = rsp_item.colour;
   assign rsp_run_last   = rsp_item.run_last;
   assign rsp_image_done = rsp_item.image_done;

endmodule
